>>> rtl/tgp_pkg.sv
// Shared types, codes and defaults for the turtle grid plotter.
`default_nettype none

package tgp_pkg;

  // Default floor edge length in cells
  localparam int GRID_SIZE_DEF = 32;

  // Width of the position and step fields on the stream ports
  localparam int FW = 5;

  // Stream widths (tdata fields packed, padded to whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;

  // Command codes carried on in_tuser
  typedef logic [2:0] req_t;
  localparam req_t REQ_PEN_UP  = 3'd0;
  localparam req_t REQ_PEN_DN  = 3'd1;
  localparam req_t REQ_TURN_R  = 3'd2;
  localparam req_t REQ_TURN_L  = 3'd3;
  localparam req_t REQ_MOVE    = 3'd4;
  localparam req_t REQ_READ    = 3'd5;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } head_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MOVE,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // One request as taken from the input stream
  typedef struct packed {
    req_t         req_type;
    logic [FW-1:0] step_count;
    logic [FW-1:0] read_row;
    logic [FW-1:0] read_col;
  } cmd_t;

  // One result; status sits in the lowest bit
  typedef struct packed {
    logic [FW-1:0] col_now;
    logic [FW-1:0] row_now;
    head_t         heading_now;
    logic          turtle_here;
    logic          cell_value;
    logic          status;
  } res_t;

  // Handshake state from the sequencer to the top level
  typedef struct packed {
    logic in_ready;
    logic res_push;
  } seq_sts_t;

endpackage

`default_nettype wire

>>> rtl/turtle_grid_plotter_core.sv
// Top level of the turtle grid plotter: stream ports, output register, sequencer, bitmap.
//
//  Channel  Dir  Handshake          Payload
//  in_      in   tvalid / tready    tuser: req_type; tdata: step_count, read_row, read_col
//  out_     out  tvalid / tready    tdata: status, cell_value, turtle_here, heading_now,
//                                          row_now, col_now
//
//  Pen, turn and unused codes pass EXEC then DONE; a read passes EXEC, RDWAIT, DONE;
//  a move of n cells that stays on the floor draws them in MOVE between EXEC and DONE,
//  one bitmap write per cycle on the memory port; a rejected or zero-length move skips MOVE.
//  After reset the bitmap is cleared one cell a cycle, all GRID_SIZE*GRID_SIZE cells
//  (1024 by default), with in_tready low.
//  A finished result waits in the output register; the next request is taken meanwhile,
//  and its result waits in the sequencer until the register drains.
`default_nettype none

module turtle_grid_plotter_core
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [4:0] step_count, [9:5] read_row,
                                                  // [14:10] read_col, [15] zero
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // [2:0] req_type
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // [0] status, [1] cell_value,
                                                  // [2] turtle_here, [4:3] heading_now,
                                                  // [9:5] row_now, [14:10] col_now,
                                                  // [15] zero
);

  localparam int NC = GRID_SIZE * GRID_SIZE;
  localparam int AW = $clog2(NC);

  cmd_t          cmd;
  seq_sts_t      sts;
  res_t          res;
  logic          push_ok;
  logic          out_valid_r;
  res_t          out_res_r;
  logic          mem_we, mem_wdata, mem_re, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  // Unpack the request
  assign cmd.req_type   = in_tuser;
  assign cmd.step_count = in_tdata[4:0];
  assign cmd.read_row   = in_tdata[9:5];
  assign cmd.read_col   = in_tdata[14:10];

  assign in_tready = sts.in_ready;
  assign push_ok   = !out_valid_r || out_tready;

  tgp_seq #(
    .GRID_SIZE (GRID_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .cmd       (cmd),
    .push_ok   (push_ok),
    .sts       (sts),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tgp_floor_mem #(
    .DEPTH (NC)
  ) u_floor_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load on push, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.res_push) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

`ifndef ASSERT_OFF
  // A result is pushed only into a free or draining output register
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    sts.res_push |-> (!out_valid_r || out_tready))
    else $error("result pushed over a waiting result");

  // One request at a time: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while one is in work");

  // Pushing a result and taking a request never coincide
  a_push_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.res_push |-> !in_tready)
    else $error("result pushed while idle");

  // A rejected move reports no cell data
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.res_push && res.status) |-> (!res.cell_value && !res.turtle_here))
    else $error("rejected move carries read data");
`endif

endmodule

`default_nettype wire

>>> rtl/tgp_floor_mem.sv
// One-bit-wide floor bitmap memory, one write and one registered read port.
`default_nettype none

module tgp_floor_mem
  import tgp_pkg::*;
#(
  parameter  int DEPTH = GRID_SIZE_DEF * GRID_SIZE_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tgp_seq.sv
// Request sequencer: turtle state, move sweep, cell reads and the clearing pass.
`default_nettype none

module tgp_seq
  import tgp_pkg::*;
#(
  parameter  int GRID_SIZE = GRID_SIZE_DEF,
  localparam int NC        = GRID_SIZE * GRID_SIZE,
  localparam int AW        = $clog2(NC)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire cmd_t          cmd,
  input  wire logic          push_ok,
  output seq_sts_t           sts,
  output res_t               res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic               mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  wire logic          mem_rdata
);

  localparam int PW = $clog2(GRID_SIZE);
  localparam int CW = ((PW > FW) ? PW : FW) + 1;
  localparam logic [AW-1:0] LAST_CELL = AW'(NC - 1);

  state_t        state_r, state_nxt;
  logic [PW-1:0] row_r, row_nxt;
  logic [PW-1:0] col_r, col_nxt;
  head_t         head_r, head_nxt;
  logic          pen_r, pen_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [PW-1:0] cur_row_r, cur_row_nxt;
  logic [PW-1:0] cur_col_r, cur_col_nxt;
  logic [FW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          status_r, status_nxt;
  logic          cell_r, cell_nxt;
  logic          here_r, here_nxt;
  logic          inrange_r, inrange_nxt;

  logic [CW-1:0] row_ext, col_ext, n_ext, rd_row_ext, rd_col_ext;
  logic          rd_inrange;
  logic          reject;
  logic [PW-1:0] step_row, step_col;
  logic [PW-1:0] addr_row, addr_col;
  logic [AW-1:0] cell_addr;

  // Widen positions for range checks
  assign row_ext    = CW'(row_r);
  assign col_ext    = CW'(col_r);
  assign n_ext      = CW'(cmd_r.step_count);
  assign rd_row_ext = CW'(cmd_r.read_row);
  assign rd_col_ext = CW'(cmd_r.read_col);
  assign rd_inrange = (rd_row_ext < CW'(GRID_SIZE)) && (rd_col_ext < CW'(GRID_SIZE));

  // Reject a move whose destination leaves the floor
  always_comb begin
    case (head_r)
      HEAD_UP:    reject = n_ext > row_ext;
      HEAD_RIGHT: reject = (col_ext + n_ext) > CW'(GRID_SIZE - 1);
      HEAD_DOWN:  reject = (row_ext + n_ext) > CW'(GRID_SIZE - 1);
      default:    reject = n_ext > col_ext;
    endcase
  end

  // Advance the sweep position one cell along the heading
  always_comb begin
    step_row = cur_row_r;
    step_col = cur_col_r;
    case (head_r)
      HEAD_UP:    step_row = cur_row_r - PW'(1);
      HEAD_RIGHT: step_col = cur_col_r + PW'(1);
      HEAD_DOWN:  step_row = cur_row_r + PW'(1);
      default:    step_col = cur_col_r - PW'(1);
    endcase
  end

  // Linear cell address: read position during dispatch, sweep position otherwise
  assign addr_row  = (state_r == ST_EXEC) ? rd_row_ext[PW-1:0] : cur_row_r;
  assign addr_col  = (state_r == ST_EXEC) ? rd_col_ext[PW-1:0] : cur_col_r;
  assign cell_addr = AW'(addr_row) * AW'(GRID_SIZE) + AW'(addr_col);

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r   <= '0;
      col_r   <= '0;
      head_r  <= HEAD_RIGHT;
      pen_r   <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      head_r  <= head_nxt;
      pen_r   <= pen_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Hold the request payload and sweep registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    cnt_r     <= cnt_nxt;
    status_r  <= status_nxt;
    cell_r    <= cell_nxt;
    here_r    <= here_nxt;
    inrange_r <= inrange_nxt;
  end

  // Next state and memory control
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    head_nxt    = head_r;
    pen_nxt     = pen_r;
    clr_nxt     = clr_r;
    cmd_nxt     = cmd_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    cell_nxt    = cell_r;
    here_nxt    = here_r;
    inrange_nxt = inrange_r;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr;
    mem_wdata   = pen_r;
    mem_re      = 1'b0;
    mem_raddr   = cell_addr;
    sts.in_ready = 1'b0;
    sts.res_push = 1'b0;

    case (state_r)
      // Zero the bitmap cell by cell after reset, up to the last cell
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 1'b0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take one request
      ST_IDLE: begin
        sts.in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt    = cmd;
          status_nxt = 1'b0;
          cell_nxt   = 1'b0;
          here_nxt   = 1'b0;
          state_nxt  = ST_EXEC;
        end
      end

      // Dispatch on the request code
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (cmd_r.req_type)
          REQ_PEN_UP: pen_nxt  = 1'b0;
          REQ_PEN_DN: pen_nxt  = 1'b1;
          REQ_TURN_R: head_nxt = head_t'(head_r + 2'd1);
          REQ_TURN_L: head_nxt = head_t'(head_r - 2'd1);
          REQ_MOVE: begin
            if (reject) begin
              status_nxt = 1'b1;
            end else if (cmd_r.step_count != '0) begin
              cur_row_nxt = row_r;
              cur_col_nxt = col_r;
              cnt_nxt     = cmd_r.step_count;
              state_nxt   = ST_MOVE;
            end
          end
          REQ_READ: begin
            mem_re      = rd_inrange;
            inrange_nxt = rd_inrange;
            state_nxt   = ST_RDWAIT;
          end
          default: ;
        endcase
      end

      // Draw one cell per cycle, then land on the destination
      ST_MOVE: begin
        mem_we      = 1'b1;
        cur_row_nxt = step_row;
        cur_col_nxt = step_col;
        cnt_nxt     = cnt_r - FW'(1);
        if (cnt_r == FW'(1)) begin
          row_nxt   = step_row;
          col_nxt   = step_col;
          state_nxt = ST_DONE;
        end
      end

      // Capture the read cell
      ST_RDWAIT: begin
        cell_nxt  = inrange_r & mem_rdata;
        here_nxt  = inrange_r && (rd_row_ext[PW-1:0] == row_r)
                    && (rd_col_ext[PW-1:0] == col_r);
        state_nxt = ST_DONE;
      end

      // Hand the result to the output register once it has room
      ST_DONE: begin
        if (push_ok) begin
          sts.res_push = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result fields: status and read data as registered, position and heading from the turtle state
  assign res.status      = status_r;
  assign res.cell_value  = cell_r;
  assign res.turtle_here = here_r;
  assign res.heading_now = head_r;
  assign res.row_now     = row_ext[FW-1:0];
  assign res.col_now     = col_ext[FW-1:0];

endmodule

`default_nettype wire

>>> test/turtle_grid_plotter_core_tb.sv
// Self-checking testbench for the turtle grid plotter core: directed script plus random commands.
module turtle_grid_plotter_core_tb;
  import tgp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = GRID_SIZE_DEF;
  localparam int RAND_CMDS = 900;
  localparam int RESULT_LAT = 40;

  // Unused command codes, expected to leave the turtle alone
  localparam req_t REQ_NOP6 = 3'd6;
  localparam req_t REQ_NOP7 = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [4:0] step_count, [9:5] read_row,
                                           // [14:10] read_col, [15] zero
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // [2:0] req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] status, [1] cell_value, [2] turtle_here,
                                           // [4:3] heading_now, [9:5] row_now, [14:10] col_now

  turtle_grid_plotter_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Turtle state as the plotter should hold it
  bit         floor_bits [GRID*GRID];
  logic [4:0] pos_row = '0;
  logic [4:0] pos_col = '0;
  head_t      facing = HEAD_RIGHT;
  logic       pen_is_down = 1'b0;

  res_t plot_expect_q [$];
  int   plot_errs = 0;
  int   req_sent = 0;
  int   res_taken = 0;

  // One row of the directed script; the w_ fields only count when chk is set
  typedef struct packed {
    req_t       op;
    logic [4:0] steps;
    logic [4:0] rrow;
    logic [4:0] rcol;
    logic       chk;
    logic       w_status;
    logic       w_cell;
    logic       w_here;
    head_t      w_head;
    logic [4:0] w_row;
    logic [4:0] w_col;
  } plot_row_t;

  plot_row_t plot_script [25] = '{
    '{REQ_READ,   5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 1'b1, HEAD_RIGHT, 5'd0, 5'd0},
    '{REQ_READ,   5'd0,  5'd31, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0},
    '{REQ_NOP6,   5'd31, 5'd31, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0},
    '{REQ_NOP7,   5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0},
    '{REQ_MOVE,   5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0},
    '{REQ_TURN_L, 5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_MOVE,   5'd1,  5'd0,  5'd0,  1'b1, 1'b1, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_TURN_L, 5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0, HEAD_LEFT,  5'd0, 5'd0},
    '{REQ_MOVE,   5'd31, 5'd0,  5'd0,  1'b1, 1'b1, 1'b0, 1'b0, HEAD_LEFT,  5'd0, 5'd0},
    '{REQ_TURN_R, 5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_TURN_R, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_PEN_DN, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_MOVE,   5'd31, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_MOVE,   5'd1,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_READ,   5'd0,  5'd0,  5'd30, 1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_READ,   5'd0,  5'd0,  5'd31, 1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_TURN_R, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_MOVE,   5'd31, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_TURN_R, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_MOVE,   5'd31, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_TURN_R, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_PEN_UP, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_MOVE,   5'd31, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_READ,   5'd0,  5'd31, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0},
    '{REQ_READ,   5'd0,  5'd31, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0, HEAD_UP,    5'd0, 5'd0}
  };

  // Free cells ahead of the turtle before it would leave the floor
  function automatic int unsigned move_room();
    case (facing)
      HEAD_UP:    return pos_row;
      HEAD_RIGHT: return GRID - 1 - pos_col;
      HEAD_DOWN:  return GRID - 1 - pos_row;
      default:    return pos_col;
    endcase
  endfunction

  // Apply one command to the turtle state and return the result it should give
  function automatic res_t plot_predict(req_t op, logic [4:0] steps, logic [4:0] rrow,
                                        logic [4:0] rcol);
    res_t res;
    int   dr;
    int   dc;
    int   i;
    res = '0;
    dr = 0;
    dc = 0;
    case (op)
      REQ_PEN_UP: pen_is_down = 1'b0;
      REQ_PEN_DN: pen_is_down = 1'b1;
      REQ_TURN_R: facing = head_t'(facing + 2'd1);
      REQ_TURN_L: facing = head_t'(facing + 2'd3);
      REQ_MOVE: begin
        if (steps > move_room()) begin
          res.status = 1'b1;
        end else begin
          case (facing)
            HEAD_UP:    dr = -1;
            HEAD_RIGHT: dc = 1;
            HEAD_DOWN:  dr = 1;
            default:    dc = -1;
          endcase
          // draw the trail, the destination cell excluded
          for (i = 0; i < int'(steps); i++) begin
            floor_bits[(int'(pos_row) + i*dr)*GRID + int'(pos_col) + i*dc] = pen_is_down;
          end
          pos_row = 5'(int'(pos_row) + int'(steps)*dr);
          pos_col = 5'(int'(pos_col) + int'(steps)*dc);
        end
      end
      REQ_READ: begin
        if (rrow < GRID && rcol < GRID) begin
          res.cell_value = floor_bits[int'(rrow)*GRID + int'(rcol)];
          res.turtle_here = (rrow == pos_row) && (rcol == pos_col);
        end
      end
      default: ;
    endcase
    res.heading_now = facing;
    res.row_now = pos_row;
    res.col_now = pos_col;
    return res;
  endfunction

  // Idle cycles before the next handshake, with stretches of back-to-back traffic
  function automatic int idle_gap(int idx);
    if ((idx / 40) % 5 == 4) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Offer one request, wait for it to be taken, then queue its expected result
  task automatic plot_send(input req_t op, input logic [4:0] steps, input logic [4:0] rrow,
                           input logic [4:0] rcol, input logic chk, input res_t typed);
    int   gap;
    res_t pred;
    gap = idle_gap(req_sent);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, rcol, rrow, steps};
    do @(posedge clk); while (!in_tready);
    pred = plot_predict(op, steps, rrow, rcol);
    plot_expect_q.push_back(chk ? typed : pred);
    req_sent++;
  endtask

  // Stimulus and end of run
  initial begin
    plot_row_t   srow;
    res_t        typed;
    req_t        op;
    logic [4:0]  steps;
    logic [4:0]  rrow;
    logic [4:0]  rcol;
    int unsigned pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script
    foreach (plot_script[k]) begin
      srow = plot_script[k];
      typed = '0;
      typed.status = srow.w_status;
      typed.cell_value = srow.w_cell;
      typed.turtle_here = srow.w_here;
      typed.heading_now = srow.w_head;
      typed.row_now = srow.w_row;
      typed.col_now = srow.w_col;
      plot_send(srow.op, srow.steps, srow.rrow, srow.rcol, srow.chk, typed);
    end

    // Random commands, moves mostly kept on the floor
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (n == RAND_CMDS / 2) begin
        // drain the plotter completely before going on
        in_tvalid <= 1'b0;
        wait (plot_expect_q.size() == 0);
        @(posedge clk);
      end
      steps = 5'($urandom);
      rrow = 5'($urandom);
      rcol = 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) op = REQ_PEN_UP;
      else if (pick < 16) op = REQ_PEN_DN;
      else if (pick < 28) op = REQ_TURN_R;
      else if (pick < 40) op = REQ_TURN_L;
      else if (pick < 72) op = REQ_MOVE;
      else if (pick < 96) op = REQ_READ;
      else if (pick < 98) op = REQ_NOP6;
      else op = REQ_NOP7;
      if (op == REQ_MOVE && $urandom_range(0, 3) != 0) begin
        steps = 5'($urandom_range(0, move_room()));
      end
      if (op == REQ_READ) begin
        // aim at the turtle's row, column or cell most of the time
        case ($urandom_range(0, 3))
          0: begin
            rrow = pos_row;
            rcol = pos_col;
          end
          1: rrow = pos_row;
          2: rcol = pos_col;
          default: ;
        endcase
      end
      plot_send(op, steps, rrow, rcol, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    wait (plot_expect_q.size() == 0);
    repeat (RESULT_LAT) @(posedge clk);
    if (plot_errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result receiver with random stalls and one long hold-off
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = (res_taken == 300) ? 400 : idle_gap(res_taken);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      res_taken++;
    end
  end

  // Compare each accepted result with the oldest expectation
  res_t got;
  res_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[14:0]);
      if (plot_expect_q.size() == 0) begin
        $error("result 0x%04h with no request pending", out_tdata);
        plot_errs++;
      end else begin
        want = plot_expect_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          plot_errs++;
        end
        if (got.cell_value !== want.cell_value) begin
          $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
          plot_errs++;
        end
        if (got.turtle_here !== want.turtle_here) begin
          $error("turtle_here: expected %0d, got %0d", want.turtle_here, got.turtle_here);
          plot_errs++;
        end
        if (got.heading_now !== want.heading_now) begin
          $error("heading_now: expected %0d, got %0d", want.heading_now, got.heading_now);
          plot_errs++;
        end
        if (got.row_now !== want.row_now) begin
          $error("row_now: expected %0d, got %0d", want.row_now, got.row_now);
          plot_errs++;
        end
        if (got.col_now !== want.col_now) begin
          $error("col_now: expected %0d, got %0d", want.col_now, got.col_now);
          plot_errs++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/tgp_pkg.sv
rtl/tgp_floor_mem.sv
rtl/tgp_seq.sv
rtl/turtle_grid_plotter_core.sv
test/turtle_grid_plotter_core_tb.sv
